// ===== rtl/core/rlh_pkg.sv =====
`timescale 1ns / 1ps

package rlh_pkg;

    // Widths of the run counter and of the bucket counters.
    localparam int RUN_BITS   = 32;
    localparam int COUNT_BITS = 32;

    // One bucket for each power of two from 2^0 to 2^32.
    localparam int NUM_BUCKETS = 33;
    localparam int INDEX_BITS  = 6;

    // Field widths of the transactions.
    localparam int ACTION_BITS = 2;
    localparam int CLASS_BITS  = 2;
    localparam int LENGTH_BITS = 33;
    localparam int FIELD_BITS  = 32;

    // Depth of the command queue between the front and back ends.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    // Width that holds both a bucket counter and the count field.
    localparam int CMP_BITS = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;

    localparam logic [RUN_BITS-1:0]   RUN_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Action codes.
    localparam logic [ACTION_BITS-1:0] ACT_EDGE  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_END   = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_READ  = 2'd2;
    localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 2'd3;

    // Class code of a cycle edge.
    localparam logic [CLASS_BITS-1:0] CYCLE_CLASS = 2'd2;

    // Commands passed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_INC,
        CMD_READ,
        CMD_CLEAR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t               op;
        logic [INDEX_BITS-1:0] addr;
        logic                  oob;
    } cmd_t;

    // Clamp a bucket counter to the width of the count field.
    function automatic logic [FIELD_BITS-1:0] count_to_field(
        input logic [COUNT_BITS-1:0] cnt
    );
        logic [CMP_BITS-1:0] wide;
        wide = CMP_BITS'(cnt);
        if (wide > CMP_BITS'({FIELD_BITS{1'b1}}))
        begin
            return '1;
        end
        return wide[FIELD_BITS-1:0];
    endfunction

endpackage

// ===== rtl/core/rlh_in_if.sv =====
`timescale 1ns / 1ps

interface rlh_in_if;
    logic                               valid;
    logic                               ready;
    logic [rlh_pkg::ACTION_BITS-1:0]    action;
    logic [rlh_pkg::CLASS_BITS-1:0]     edge_class;
    logic [rlh_pkg::INDEX_BITS-1:0]     bucket_index;

    modport source (output valid, action, edge_class, bucket_index, input ready);
    modport sink   (input valid, action, edge_class, bucket_index, output ready);
endinterface

// ===== rtl/core/rlh_out_if.sv =====
`timescale 1ns / 1ps

interface rlh_out_if;
    logic                               valid;
    logic                               ready;
    logic [rlh_pkg::LENGTH_BITS-1:0]    bucket_length;
    logic [rlh_pkg::FIELD_BITS-1:0]     bucket_count;

    modport source (output valid, bucket_length, bucket_count, input ready);
    modport sink   (input valid, bucket_length, bucket_count, output ready);
endinterface

// ===== rtl/core/rlh_front.sv =====
`timescale 1ns / 1ps

module rlh_front (
    input  logic          clk,
    input  logic          rst_n,
    rlh_in_if.sink        in_ch,
    input  logic          q_full,
    output logic          push,
    output rlh_pkg::cmd_t push_cmd
);

    logic [rlh_pkg::RUN_BITS-1:0]   run_reg;
    logic [rlh_pkg::RUN_BITS-1:0]   run_next;
    logic [rlh_pkg::INDEX_BITS-1:0] k_reg;
    logic [rlh_pkg::INDEX_BITS-1:0] k_next;
    logic                           accept;

    // Any transaction is taken while the queue has room.
    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;

    // Track the current run and its bucket. The bucket index moves up by one
    // each time the run grows past the power of two it currently stands for.
    always_comb
    begin
        run_next = run_reg;
        k_next   = k_reg;
        push     = 1'b0;
        push_cmd = '{op: rlh_pkg::CMD_INC, addr: k_reg, oob: 1'b0};
        if (accept)
        begin
            case (in_ch.action)
                rlh_pkg::ACT_EDGE:
                begin
                    if (in_ch.edge_class == rlh_pkg::CYCLE_CLASS)
                    begin
                        if (run_reg != rlh_pkg::RUN_MAX)
                        begin
                            run_next = run_reg + rlh_pkg::RUN_BITS'(1);
                            if ((run_reg != '0) &&
                                (run_reg == (rlh_pkg::RUN_BITS'(1) << k_reg)))
                            begin
                                k_next = k_reg + rlh_pkg::INDEX_BITS'(1);
                            end
                        end
                    end
                    else if (run_reg != '0)
                    begin
                        push     = 1'b1;
                        run_next = '0;
                        k_next   = '0;
                    end
                end
                rlh_pkg::ACT_END:
                begin
                    if (run_reg != '0)
                    begin
                        push     = 1'b1;
                        run_next = '0;
                        k_next   = '0;
                    end
                end
                rlh_pkg::ACT_READ:
                begin
                    push     = 1'b1;
                    push_cmd = '{op:   rlh_pkg::CMD_READ,
                                 addr: in_ch.bucket_index,
                                 oob:  (in_ch.bucket_index >=
                                        rlh_pkg::INDEX_BITS'(rlh_pkg::NUM_BUCKETS))};
                end
                rlh_pkg::ACT_CLEAR:
                begin
                    push     = 1'b1;
                    push_cmd = '{op: rlh_pkg::CMD_CLEAR, addr: '0, oob: 1'b0};
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
            k_reg   <= '0;
        end
        else
        begin
            run_reg <= run_next;
            k_reg   <= k_next;
        end
    end

    // An empty run always maps to bucket zero.
    a_idle_bucket: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg == '0) |-> (k_reg == '0))
        else $error("bucket index not cleared with the run");

    // A run that closes is pushed as an increment of its bucket.
    a_close_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (run_reg != '0) && (run_next == '0)) |->
        (push && (push_cmd.op == rlh_pkg::CMD_INC)))
        else $error("closed run was not queued");

endmodule

// ===== rtl/core/rlh_queue.sv =====
`timescale 1ns / 1ps

module rlh_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rlh_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output rlh_pkg::cmd_t pop_cmd
);

    rlh_pkg::cmd_t                 entry_reg [rlh_pkg::QUEUE_DEPTH];
    logic [rlh_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [rlh_pkg::QPTR_BITS-1:0] wr_ptr_next;
    logic [rlh_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [rlh_pkg::QPTR_BITS-1:0] rd_ptr_next;
    logic [rlh_pkg::QPTR_BITS:0]   count_reg;
    logic [rlh_pkg::QPTR_BITS:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full      = (count_reg == (rlh_pkg::QPTR_BITS+1)'(rlh_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + rlh_pkg::QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + rlh_pkg::QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (rlh_pkg::QPTR_BITS+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (rlh_pkg::QPTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/rlh_back.sv =====
`timescale 1ns / 1ps

module rlh_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_not_empty,
    input  rlh_pkg::cmd_t q_cmd,
    output logic          pop,
    rlh_out_if.source     out_ch
);

    logic [rlh_pkg::COUNT_BITS-1:0]  mem [rlh_pkg::NUM_BUCKETS];
    logic [rlh_pkg::NUM_BUCKETS-1:0] valid_reg;
    logic [rlh_pkg::NUM_BUCKETS-1:0] valid_next;

    logic                            b_valid_reg;
    rlh_pkg::cmd_t                   b_cmd_reg;
    logic [rlh_pkg::COUNT_BITS-1:0]  rdata_reg;

    logic                            fwd_valid_reg;
    logic [rlh_pkg::INDEX_BITS-1:0]  fwd_addr_reg;
    logic [rlh_pkg::COUNT_BITS-1:0]  fwd_data_reg;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [rlh_pkg::LENGTH_BITS-1:0] out_len_reg;
    logic [rlh_pkg::FIELD_BITS-1:0]  out_cnt_reg;

    logic                            b_adv;
    logic                            b_take;
    logic                            b_hold;
    logic                            is_inc;
    logic                            is_read;
    logic                            is_clear;
    logic                            out_load;
    logic                            mem_rd;
    logic [rlh_pkg::COUNT_BITS-1:0]  cur_count;
    logic [rlh_pkg::COUNT_BITS-1:0]  new_count;

    // Stage control: a read waits only for a full, stalled output register.
    assign is_inc   = (b_cmd_reg.op == rlh_pkg::CMD_INC);
    assign is_read  = (b_cmd_reg.op == rlh_pkg::CMD_READ);
    assign is_clear = (b_cmd_reg.op == rlh_pkg::CMD_CLEAR);
    assign b_adv    = b_valid_reg && !(is_read && out_valid_reg && !out_ch.ready);
    assign b_hold   = b_valid_reg && !b_adv;
    assign b_take   = !b_hold;
    assign pop      = q_not_empty && b_take;
    assign mem_rd   = pop && !q_cmd.oob;
    assign out_load = b_adv && is_read;

    // Current bucket value: an unwritten or cleared entry reads as zero, and
    // the write of the previous step is forwarded past the memory read.
    always_comb
    begin
        if (!valid_reg[b_cmd_reg.addr] || b_cmd_reg.oob)
        begin
            cur_count = '0;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == b_cmd_reg.addr))
        begin
            cur_count = fwd_data_reg;
        end
        else
        begin
            cur_count = rdata_reg;
        end
        new_count = (cur_count == rlh_pkg::COUNT_MAX) ?
                    cur_count : cur_count + rlh_pkg::COUNT_BITS'(1);
    end

    // Valid bits: the clear transaction drops them all at once.
    always_comb
    begin
        valid_next = valid_reg;
        if (b_adv && is_clear)
        begin
            valid_next = '0;
        end
        else if (b_adv && is_inc)
        begin
            valid_next[b_cmd_reg.addr] = 1'b1;
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            if (b_take)
            begin
                b_valid_reg   <= q_not_empty;
                fwd_valid_reg <= b_adv && is_inc;
            end
        end
    end

    // Stage payload and forwarding data.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_cmd_reg <= q_cmd;
        end
        if (b_take)
        begin
            fwd_addr_reg <= b_cmd_reg.addr;
            fwd_data_reg <= new_count;
        end
        if (out_load)
        begin
            out_len_reg <= b_cmd_reg.oob ? '0 :
                           (rlh_pkg::LENGTH_BITS'(1) << b_cmd_reg.addr);
            out_cnt_reg <= rlh_pkg::count_to_field(cur_count);
        end
    end

    // Bucket counter memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (b_adv && is_inc)
        begin
            mem[b_cmd_reg.addr] <= new_count;
        end
        if (mem_rd)
        begin
            rdata_reg <= mem[q_cmd.addr];
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.bucket_length = out_len_reg;
    assign out_ch.bucket_count  = out_cnt_reg;

    // A clear leaves every bucket reading as zero.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && is_clear) |=> (valid_reg == '0))
        else $error("clear left a bucket valid");

    // An increment marks its bucket valid and arms the forwarding path.
    a_inc_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && is_inc) |=> (fwd_valid_reg && valid_reg[fwd_addr_reg]))
        else $error("increment not forwarded");

    // A new result appears only when a read leaves the stage.
    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(b_adv && is_read))
        else $error("result without a read");

endmodule

// ===== rtl/core/run_length_pow2_histogram_core.sv =====
`timescale 1ns / 1ps

// Run-length histogram with power-of-two buckets. Each input transaction is
// an edge sample, an end of stream, a bucket read or a histogram clear; only
// a read returns an output transaction, carrying 2^bucket_index and that
// bucket's saturating count (zeros for an index above 32). The block takes
// one transaction per cycle while the queue has room. The front end tracks
// the run and its bucket index as it grows, so closing a run needs no search;
// a four-entry command queue feeds the back end, whose bucket counters live
// in a 33-entry memory updated by read-modify-write, one command per cycle,
// with the last write forwarded. A read result passes the queue, the back-end
// stage and the output register. Only a read result held by the output side
// stalls the back end; input ready drops once the queue fills behind it.
// Reset and the clear transaction empty the histogram at once through
// per-bucket valid bits, so there is no clearing pass after reset.
module run_length_pow2_histogram_core (
    input  logic       clk,
    input  logic       rst_n,
    rlh_in_if.sink     in_ch,
    rlh_out_if.source  out_ch
);

    logic          q_full;
    logic          q_push;
    rlh_pkg::cmd_t q_push_cmd;
    logic          q_pop;
    logic          q_not_empty;
    rlh_pkg::cmd_t q_pop_cmd;

    // Run tracking and command generation.
    rlh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    // Command queue between the two ends.
    rlh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (q_pop_cmd)
    );

    // Bucket counters and result register.
    rlh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_cmd       (q_pop_cmd),
        .pop         (q_pop),
        .out_ch      (out_ch)
    );

endmodule
